// ===== rtl/ffip_pkg.sv =====
// Character constants, status codes and character class helpers for the integer parser.
package ffip_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  // Result status codes
  localparam logic [1:0] STAT_POS  = 2'd0;
  localparam logic [1:0] STAT_NEG  = 2'd1;
  localparam logic [1:0] STAT_NULL = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PARSE = 1'b1;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== rtl/free_format_integer_parser_top.sv =====
// Top level of the free-format decimal integer parser with its character buffer.
//
// The block holds a buffer of MAX_LEN characters in one synchronous memory
// with a registered read. An input beat with in_tuser = 0 writes char_code
// at 1-based position (ignored for position 0 or above MAX_LEN) and produces
// no result. A beat with in_tuser = 1 parses from position (0 counts as 1):
// skip C whitespace, take an optional sign, then decimal digits, and return
// the value sign-extended to 64 bits, a status (positive, negative including
// -0, null, overflow) and the position where the following field starts (one
// comma, or else any blanks, are stepped over). On overflow the digits are
// still consumed and the value saturates to the VALUE_BITS range. A parse
// reads one buffer character per cycle through the single memory read port:
// it takes the beat, examines each character in turn (leading whitespace,
// sign, digits, the end character, any blanks after it, and the character
// that stops each scan), then loads the result; a null field adds a rescan
// from the start position over blanks, letters and '+'. One parse is worked
// at a time; a finished result waits in the output register while the next
// beat is taken. After reset the buffer is cleared to terminators by a pass
// over all MAX_LEN cells, during which in_tready stays low.
module free_format_integer_parser_top #(
  parameter int MAX_LEN    = 256,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] position, [16:9] char_code, rest zero
  input  logic [0:0]  in_tuser,   // [0] action (0 write, 1 parse)
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [63:0] value, [72:64] next_position, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int IW = ((AW > 9) ? AW : 9) + 1;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WS    = 3'd2;
  localparam logic [2:0] S_SGN   = 3'd3;
  localparam logic [2:0] S_DIG   = 3'd4;
  localparam logic [2:0] S_NUL   = 3'd5;
  localparam logic [2:0] S_BLK   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // Character buffer
  logic [7:0] mem [MAX_LEN];
  logic [7:0] q_r;
  logic       oob_r;

  logic [2:0]            state_r, state_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [IW-1:0]         start_r, start_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  null_r, null_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [8:0]            next_r, next_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           out_value_r;
  logic [1:0]            out_status_r;
  logic [8:0]            out_next_r;
  logic                  out_load;

  logic                  in_fire;
  logic [8:0]            in_pos;
  logic [7:0]            in_char;
  logic [IW-1:0]         pos_ext;
  logic [IW-1:0]         wr_idx;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [7:0]            wd;
  logic [7:0]            c;

  logic [VALUE_BITS-1:0] acc_mag;
  logic                  acc_ovf;
  logic [VALUE_BITS-1:0] signed_mag;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_pos    = in_tdata[8:0];
  assign in_char   = in_tdata[16:9];
  assign pos_ext   = IW'(in_pos);
  assign wr_idx    = pos_ext - IW'(1);

  // Character seen this cycle; reads beyond the buffer give the terminator
  assign c = oob_r ? 8'h00 : q_r;

  ffip_acc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_acc (
    .neg        (neg_r),
    .ovf        (ovf_r),
    .mag        (mag_r),
    .digit_char (c),
    .mag_out    (acc_mag),
    .ovf_out    (acc_ovf)
  );

  // Buffer write port: clearing pass after reset, or a write beat
  always_comb begin
    we = 1'b0;
    wa = cur_r[AW-1:0];
    wd = 8'h00;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (in_fire && (in_tuser[0] == ffip_pkg::ACT_WRITE) && (in_pos != 9'd0) &&
                 (pos_ext <= IW'(MAX_LEN))) begin
      we = 1'b1;
      wa = wr_idx[AW-1:0];
      wd = in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q_r   <= mem[cur_nxt[AW-1:0]];
    oob_r <= (cur_nxt >= IW'(MAX_LEN));
  end

  // Sequencer: one character examined per cycle, the next one requested
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    start_nxt = start_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    null_nxt  = null_r;
    mag_nxt   = mag_r;
    next_nxt  = next_r;
    out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cur_nxt = cur_r + IW'(1);
        if (cur_r == IW'(MAX_LEN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && (in_tuser[0] == ffip_pkg::ACT_PARSE)) begin
          start_nxt = (in_pos == 9'd0) ? '0 : wr_idx;
          cur_nxt   = (in_pos == 9'd0) ? '0 : wr_idx;
          neg_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          null_nxt  = 1'b0;
          mag_nxt   = '0;
          state_nxt = S_WS;
        end
      end
      S_WS: begin
        if (ffip_pkg::is_ws(c)) begin
          cur_nxt = cur_r + IW'(1);
        end else if ((c == ffip_pkg::CH_PLUS) || (c == ffip_pkg::CH_MINUS)) begin
          neg_nxt   = (c == ffip_pkg::CH_MINUS);
          cur_nxt   = cur_r + IW'(1);
          state_nxt = S_SGN;
        end else if (ffip_pkg::is_digit(c)) begin
          mag_nxt   = acc_mag;
          ovf_nxt   = acc_ovf;
          cur_nxt   = cur_r + IW'(1);
          state_nxt = S_DIG;
        end else begin
          // No number: rescan from the start over blanks, letters and '+'
          null_nxt  = 1'b1;
          cur_nxt   = start_r;
          state_nxt = S_NUL;
        end
      end
      S_SGN: begin
        if (ffip_pkg::is_digit(c)) begin
          mag_nxt   = acc_mag;
          ovf_nxt   = acc_ovf;
          cur_nxt   = cur_r + IW'(1);
          state_nxt = S_DIG;
        end else begin
          null_nxt  = 1'b1;
          cur_nxt   = start_r;
          state_nxt = S_NUL;
        end
      end
      S_DIG, S_NUL: begin
        if ((state_r == S_DIG) && ffip_pkg::is_digit(c)) begin
          mag_nxt = acc_mag;
          ovf_nxt = acc_ovf;
          cur_nxt = cur_r + IW'(1);
        end else if ((state_r == S_NUL) &&
                     (ffip_pkg::is_blank(c) || ffip_pkg::is_letter(c) ||
                      (c == ffip_pkg::CH_PLUS))) begin
          cur_nxt = cur_r + IW'(1);
        end else if (c == ffip_pkg::CH_COMMA) begin
          // Field ends here: step over one comma
          next_nxt  = 9'(cur_r + IW'(2));
          state_nxt = S_OUT;
        end else if (ffip_pkg::is_blank(c)) begin
          cur_nxt   = cur_r + IW'(1);
          state_nxt = S_BLK;
        end else begin
          next_nxt  = 9'(cur_r + IW'(1));
          state_nxt = S_OUT;
        end
      end
      S_BLK: begin
        if (ffip_pkg::is_blank(c)) begin
          cur_nxt = cur_r + IW'(1);
        end else begin
          next_nxt  = 9'(cur_r + IW'(1));
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign signed_mag = neg_r ? (VALUE_BITS'(0) - mag_r) : mag_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    neg_r   <= neg_nxt;
    ovf_r   <= ovf_nxt;
    null_r  <= null_nxt;
    mag_r   <= mag_nxt;
    next_r  <= next_nxt;
    if (out_load) begin
      out_next_r <= next_r;
      if (null_r) begin
        out_value_r  <= 64'd0;
        out_status_r <= ffip_pkg::STAT_NULL;
      end else begin
        out_value_r  <= 64'(signed'(signed_mag));
        out_status_r <= ovf_r ? ffip_pkg::STAT_OVF :
                        (neg_r ? ffip_pkg::STAT_NEG : ffip_pkg::STAT_POS);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_next_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/ffip_acc.sv =====
// Decimal digit accumulator: magnitude times ten plus digit, with saturation.
module ffip_acc #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  neg,
  input  logic                  ovf,
  input  logic [VALUE_BITS-1:0] mag,
  input  logic [7:0]            digit_char,
  output logic [VALUE_BITS-1:0] mag_out,
  output logic                  ovf_out
);

  localparam int WW = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] limit;
  logic [3:0]            digit;
  logic [WW-1:0]         mag_w;
  logic [WW-1:0]         wide;

  // Largest magnitude allowed: 2^(N-1) after a minus sign, 2^(N-1)-1 otherwise
  assign limit = neg ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
  assign digit = 4'(digit_char - ffip_pkg::CH_ZERO);
  assign mag_w = {4'b0, mag};
  assign wide  = (mag_w << 3) + (mag_w << 1) + WW'(digit);

  always_comb begin
    if (ovf) begin
      mag_out = mag;
      ovf_out = 1'b1;
    end else if (wide > {4'b0, limit}) begin
      mag_out = limit;
      ovf_out = 1'b1;
    end else begin
      mag_out = wide[VALUE_BITS-1:0];
      ovf_out = 1'b0;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the decimal integer parser and its character buffer.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_CHARS = 256;
  localparam int VALUE_W   = 64;
  localparam int BEATS_PER_PHASE = 435;

  typedef struct packed {
    logic       act;
    logic [8:0] pos;
    logic [7:0] code;
  } char_cmd_t;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
    logic [8:0]  next_pos;
  } field_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [8:0] position, [16:9] char_code, rest zero
  logic [0:0]  in_tuser = '0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // [63:0] value, [72:64] next_position, rest zero
  logic [1:0]  out_tuser;       // [1:0] status

  free_format_integer_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow copy of the character buffer, updated as beats are accepted
  logic [7:0]    shadow_chars [MAX_CHARS];
  char_cmd_t     pending_cmds [$];
  char_cmd_t     cmd_on_bus;
  field_result_t expected_fields [$];
  logic [7:0]    draft_text [$];
  int            field_starts [$];

  int   queued_total   = 0;
  int   error_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  logic hold_go        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] char_at(input int idx);
    return (idx < MAX_CHARS) ? shadow_chars[idx] : 8'd0;
  endfunction

  function automatic logic char_ws(input logic [7:0] c);
    return c == ffip_pkg::CH_SPACE || c == ffip_pkg::CH_TAB || c == ffip_pkg::CH_LF ||
           c == ffip_pkg::CH_VT || c == ffip_pkg::CH_FF || c == ffip_pkg::CH_CR;
  endfunction

  function automatic logic char_blank(input logic [7:0] c);
    return c == ffip_pkg::CH_SPACE || c == ffip_pkg::CH_TAB;
  endfunction

  function automatic logic char_alpha(input logic [7:0] c);
    return (c >= ffip_pkg::CH_UC_A && c <= ffip_pkg::CH_UC_Z) ||
           (c >= ffip_pkg::CH_LC_A && c <= ffip_pkg::CH_LC_Z);
  endfunction

  function automatic logic char_num(input logic [7:0] c);
    return c >= ffip_pkg::CH_ZERO && c <= ffip_pkg::CH_NINE;
  endfunction

  function automatic field_result_t parse_field(input logic [8:0] pos);
    field_result_t r;
    int            start, i, stop, nxt;
    logic          minus, ovf;
    logic [63:0]   mag, limit, digit;
    start = (pos == 0) ? 0 : int'(pos) - 1;
    i     = start;
    minus = 1'b0;
    ovf   = 1'b0;
    mag   = '0;
    while (char_ws(char_at(i))) i++;
    if (char_at(i) == ffip_pkg::CH_PLUS || char_at(i) == ffip_pkg::CH_MINUS) begin
      minus = (char_at(i) == ffip_pkg::CH_MINUS);
      i++;
    end
    if (!char_num(char_at(i))) begin
      // no digits: rescan from the start over blanks, letters and plus signs
      r.status = ffip_pkg::STAT_NULL;
      r.value  = '0;
      stop     = start;
      while (char_blank(char_at(stop)) || char_alpha(char_at(stop)) ||
             char_at(stop) == ffip_pkg::CH_PLUS) stop++;
    end else begin
      limit = (64'd1 << (VALUE_W - 1)) - (minus ? 64'd0 : 64'd1);
      while (char_num(char_at(i))) begin
        digit = {56'd0, char_at(i) - ffip_pkg::CH_ZERO};
        // saturate once, but keep consuming digits
        if (!ovf) begin
          if (mag > (limit - digit) / 64'd10) begin
            ovf = 1'b1;
            mag = limit;
          end else begin
            mag = mag * 64'd10 + digit;
          end
        end
        i++;
      end
      stop     = i;
      r.value  = minus ? -mag : mag;
      r.status = ovf ? ffip_pkg::STAT_OVF : (minus ? ffip_pkg::STAT_NEG : ffip_pkg::STAT_POS);
    end
    nxt = stop + 1;
    if (char_at(stop) == ffip_pkg::CH_COMMA) begin
      nxt++;
    end else begin
      i = stop;
      while (char_blank(char_at(i))) begin
        nxt++;
        i++;
      end
    end
    r.next_pos = nxt[8:0];
    return r;
  endfunction

  task automatic apply_cmd(input char_cmd_t c);
    if (c.act == ffip_pkg::ACT_WRITE) begin
      if (c.pos >= 1 && c.pos <= MAX_CHARS) shadow_chars[c.pos - 1] = c.code;
    end else begin
      expected_fields.push_back(parse_field(c.pos));
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_cmd(input logic act, input int pos, input int code);
    char_cmd_t c;
    c.act  = act;
    c.pos  = pos[8:0];
    c.code = code[7:0];
    pending_cmds.push_back(c);
    queued_total++;
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(5))
      0:       return ffip_pkg::CH_SPACE;
      1:       return ffip_pkg::CH_TAB;
      2:       return ffip_pkg::CH_LF;
      3:       return ffip_pkg::CH_VT;
      4:       return ffip_pkg::CH_FF;
      default: return ffip_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(1) ? ffip_pkg::CH_UC_A + 8'($urandom_range(25))
                             : ffip_pkg::CH_LC_A + 8'($urandom_range(25));
  endfunction

  task automatic add_digits(input int n);
    repeat (n) draft_text.push_back(ffip_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_number();
    string lim_digits;
    int    kind, sgn;
    lim_digits = "922337203685477580";
    kind = $urandom_range(11);
    sgn  = $urandom_range(9);
    // near the limit the sign decides where saturation starts, so split evenly
    if (kind == 6 || kind == 7) sgn = $urandom_range(1) ? 0 : 5;
    if (sgn == 0) draft_text.push_back(ffip_pkg::CH_MINUS);
    else if (sgn == 1 || sgn == 2) draft_text.push_back(ffip_pkg::CH_MINUS);
    else if (sgn == 3) draft_text.push_back(ffip_pkg::CH_PLUS);
    case (kind)
      0, 1, 2, 3, 4: add_digits($urandom_range(1, 6));
      5:             add_digits($urandom_range(7, 18));
      6, 7: begin
        for (int k = 0; k < lim_digits.len(); k++) draft_text.push_back(lim_digits[k]);
        add_digits($urandom_range(1, 4) == 1 ? 2 : 1);
      end
      8:  add_digits($urandom_range(19, 24));
      9: begin
        repeat ($urandom_range(1, 4)) draft_text.push_back(ffip_pkg::CH_ZERO);
        add_digits($urandom_range(1, 3));
      end
      10: draft_text.push_back(ffip_pkg::CH_ZERO);
      default: repeat ($urandom_range(19, 22)) draft_text.push_back(ffip_pkg::CH_NINE);
    endcase
  endtask

  task automatic add_non_number();
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 5)) draft_text.push_back(pick_letter());
      1: draft_text.push_back(ffip_pkg::CH_MINUS);
      2: begin
        draft_text.push_back(ffip_pkg::CH_PLUS);
        draft_text.push_back(pick_letter());
      end
      default: ;  // empty field
    endcase
  endtask

  task automatic add_separator();
    case ($urandom_range(9))
      0, 1: draft_text.push_back(ffip_pkg::CH_COMMA);
      2: begin
        draft_text.push_back(ffip_pkg::CH_COMMA);
        draft_text.push_back(ffip_pkg::CH_SPACE);
      end
      3: draft_text.push_back(ffip_pkg::CH_SPACE);
      4: repeat ($urandom_range(2, 4))
           draft_text.push_back($urandom_range(1) ? ffip_pkg::CH_SPACE : ffip_pkg::CH_TAB);
      5: begin
        repeat ($urandom_range(1, 3)) draft_text.push_back(pick_letter());
        draft_text.push_back(ffip_pkg::CH_SPACE);
      end
      6: begin
        draft_text.push_back(ffip_pkg::CH_TAB);
        draft_text.push_back(ffip_pkg::CH_COMMA);
      end
      7: draft_text.push_back(pick_ws());
      8: draft_text.push_back(8'($urandom_range(1, 255)));
      default: draft_text.push_back(ffip_pkg::CH_MINUS);
    endcase
  endtask

  // Build one line of fields, write it at base, then parse at field starts
  // and at up to two random spots in or just around it.
  task automatic queue_line(input int base, input int nfields);
    int start_pos;
    draft_text.delete();
    field_starts.delete();
    for (int k = 0; k < nfields; k++) begin
      if ($urandom_range(1)) field_starts.push_back(draft_text.size());
      if ($urandom_range(2) == 0)
        repeat ($urandom_range(1, 3)) draft_text.push_back(pick_ws());
      if ($urandom_range(1)) field_starts.push_back(draft_text.size());
      if ($urandom_range(4) != 0) add_number();
      else add_non_number();
      add_separator();
    end
    if ($urandom_range(6) != 0) draft_text.push_back(8'd0);
    foreach (draft_text[k])
      if (base + k <= 511) queue_cmd(ffip_pkg::ACT_WRITE, base + k, draft_text[k]);
    foreach (field_starts[k])
      if ($urandom_range(9) != 0) queue_cmd(ffip_pkg::ACT_PARSE, base + field_starts[k], 0);
    repeat ($urandom_range(0, 2)) begin
      start_pos = $urandom_range(base + draft_text.size() + 1, base - 1);
      queue_cmd(ffip_pkg::ACT_PARSE, start_pos, $urandom_range(255));
    end
  endtask

  task automatic queue_noise(input int n);
    repeat (n) queue_cmd(logic'($urandom_range(1)), $urandom_range(511), $urandom_range(255));
  endtask

  task automatic queue_phase();
    int first;
    first = queued_total;
    while (queued_total - first < BEATS_PER_PHASE) begin
      if ($urandom_range(6) == 0) begin
        queue_noise($urandom_range(1, 8));
      end else if ($urandom_range(7) == 0) begin
        // run into the buffer end: writes past it drop, reads there see terminators
        queue_line($urandom_range(235, 256), $urandom_range(1, 5));
      end else begin
        queue_line($urandom_range(1, 200), $urandom_range(1, 6));
      end
    end
  endtask

  task automatic queue_directed();
    queue_cmd(ffip_pkg::ACT_PARSE, 1, 0);            // empty buffer
    queue_cmd(ffip_pkg::ACT_PARSE, 0, 8'hFF);        // position zero counts as one
    queue_cmd(ffip_pkg::ACT_WRITE, 0, 8'hFF);        // out of range writes drop
    queue_cmd(ffip_pkg::ACT_WRITE, 257, CH_FIVE());
    queue_cmd(ffip_pkg::ACT_WRITE, 511, 8'hAA);
    queue_cmd(ffip_pkg::ACT_WRITE, 256, ffip_pkg::CH_ZERO + 8'd7);
    queue_cmd(ffip_pkg::ACT_PARSE, 256, 0);          // last cell, end falls past the buffer
    queue_cmd(ffip_pkg::ACT_PARSE, 257, 0);
    queue_cmd(ffip_pkg::ACT_PARSE, 511, 8'hFF);
    // "-0,a 9" at the head of the buffer
    queue_cmd(ffip_pkg::ACT_WRITE, 1, ffip_pkg::CH_MINUS);
    queue_cmd(ffip_pkg::ACT_WRITE, 2, ffip_pkg::CH_ZERO);
    queue_cmd(ffip_pkg::ACT_WRITE, 3, ffip_pkg::CH_COMMA);
    queue_cmd(ffip_pkg::ACT_WRITE, 4, ffip_pkg::CH_LC_A);
    queue_cmd(ffip_pkg::ACT_WRITE, 5, ffip_pkg::CH_SPACE);
    queue_cmd(ffip_pkg::ACT_WRITE, 6, ffip_pkg::CH_NINE);
    queue_cmd(ffip_pkg::ACT_PARSE, 1, 0);            // negative zero
    queue_cmd(ffip_pkg::ACT_PARSE, 4, 0);            // null over a letter and a blank
    queue_cmd(ffip_pkg::ACT_PARSE, 6, 0);
    queue_cmd(ffip_pkg::ACT_PARSE, 3, 0);            // comma alone gives null
  endtask

  function automatic logic [7:0] CH_FIVE();
    return ffip_pkg::CH_ZERO + 8'd5;
  endfunction

  // ---------------------------------------------------------------- input driver

  always @(posedge clk) begin : cmd_driver
    logic send_now;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) apply_cmd(cmd_on_bus);
      // advance only when the bus is empty or the current beat was taken
      if (!in_tvalid || in_tready) begin
        send_now = (pending_cmds.size() > 0) && ($urandom_range(99) >= send_idle_pct);
        if (send_now) begin
          cmd_on_bus = pending_cmds.pop_front();
          in_tdata <= {7'd0, cmd_on_bus.code, cmd_on_bus.pos};
          in_tuser <= cmd_on_bus.act;
        end
        in_tvalid <= send_now;
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  // Long receiver hold-off, loaded on request and counted down here
  always @(posedge clk) begin
    if (hold_go) hold_left <= 1500;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : result_monitor
    field_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_fields.size() == 0) begin
          $error("unexpected result beat: value %0d status %0d next_position %0d",
                 $signed(out_tdata[63:0]), out_tuser, out_tdata[72:64]);
          error_count++;
        end else begin
          want = expected_fields.pop_front();
          if (out_tdata[63:0] !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value),
                   $signed(out_tdata[63:0]));
            error_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            error_count++;
          end
          if (out_tdata[72:64] !== want.next_pos) begin
            $error("next_position: expected %0d, got %0d", want.next_pos,
                   out_tdata[72:64]);
            error_count++;
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int k = 0; k < MAX_CHARS; k++) shadow_chars[k] = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed();
    while (pending_cmds.size() > 0) @(posedge clk);

    // no idling, with a long receiver hold-off to back the block up
    @(posedge clk);
    hold_go <= 1'b1;
    queue_phase();
    @(posedge clk);
    hold_go <= 1'b0;
    while (pending_cmds.size() > 0) @(posedge clk);

    send_idle_pct = 71;
    queue_phase();
    while (pending_cmds.size() > 0) @(posedge clk);

    send_idle_pct  = 0;
    recv_stall_pct = 71;
    queue_phase();
    while (pending_cmds.size() > 0) @(posedge clk);

    send_idle_pct  = 13;
    recv_stall_pct = 13;
    queue_phase();
    while (pending_cmds.size() > 0 || in_tvalid) @(posedge clk);

    // drain: every parse result, then enough cycles for a full-buffer rescan
    recv_stall_pct = 0;
    while (expected_fields.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
